// ===== rtl/core/wsdf_pkg.sv =====
// websocket frame deframer package: parse phase, event, opcode and length codes, result record
// no dependencies

package wsdf_pkg;

	localparam int unsigned PHASE_W = 3;
	localparam int unsigned EVENT_W = 4;

	localparam logic [PHASE_W-1:0] PH_HDR0  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_HDR1  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_EXTHI = 3'd2;
	localparam logic [PHASE_W-1:0] PH_EXTLO = 3'd3;
	localparam logic [PHASE_W-1:0] PH_MASK  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_DATA  = 3'd5;

	localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
	localparam logic [EVENT_W-1:0] EV_TEXT     = 4'd1;
	localparam logic [EVENT_W-1:0] EV_BINARY   = 4'd2;
	localparam logic [EVENT_W-1:0] EV_FRAGMENT = 4'd3;
	localparam logic [EVENT_W-1:0] EV_PING     = 4'd4;
	localparam logic [EVENT_W-1:0] EV_PONG     = 4'd5;
	localparam logic [EVENT_W-1:0] EV_CLOSE    = 4'd6;
	localparam logic [EVENT_W-1:0] EV_BADOP    = 4'd7;
	localparam logic [EVENT_W-1:0] EV_BADLEN   = 4'd8;

	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'h7F;

	typedef struct packed {
		logic               data_valid;
		logic [7:0]         data_byte;
		logic               frame_end;
		logic [EVENT_W-1:0] event_code;
		logic               is_closed;
	} result_t;

endpackage

// ===== rtl/core/websocket_frame_deframer_core.sv =====
// websocket frame deframer top level: header parser, payload unmasking, result register
// depends on wsdf_pkg

// Takes one received byte per cycle and gives at most one result per byte. Every
// byte is parsed in the cycle it is accepted and its result, if any, is registered in a
// single output register, so the block sustains one byte per clock; the only stall
// comes from a result still waiting in that output register while the downstream
// side holds m_axis_tready low. Header bytes that do not end a frame give no result.
// After a close frame or length code 127 every byte gives a result with only
// is_closed set, until reset.
module websocket_frame_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // data_byte
	output logic [5:0] m_axis_tuser,   // data_valid, event_code[3:0], is_closed
	output logic       m_axis_tlast    // frame_end
);

	logic [wsdf_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic                         fin_q, fin_d;
	logic [3:0]                   opcode_q, opcode_d;
	logic                         masked_q, masked_d;
	logic [31:0]                  key_q, key_d;
	logic [15:0]                  len_q, len_d;
	logic [15:0]                  idx_q, idx_d;
	logic                         frag_bin_q, frag_bin_d;
	logic                         closed_q, closed_d;

	logic                         out_valid_q;
	wsdf_pkg::result_t            out_q;
	wsdf_pkg::result_t            res;
	logic                         res_valid;
	logic                         accept;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		logic [7:0]  b;
		logic [15:0] idx_inc;
		logic [7:0]  key_byte;
		logic        end_frame;
		logic        end_dv;
		logic [7:0]  end_db;
		logic        need_hdr_done;
		logic        need_after_len;
		logic [wsdf_pkg::EVENT_W-1:0] ev;

		b              = s_axis_tdata;
		idx_inc        = idx_q + 16'd1;
		key_byte       = key_q[{idx_q[1:0], 3'b000} +: 8];
		end_frame      = 1'b0;
		end_dv         = 1'b0;
		end_db         = 8'd0;
		need_hdr_done  = 1'b0;
		need_after_len = 1'b0;
		ev             = wsdf_pkg::EV_NONE;

		phase_d    = phase_q;
		fin_d      = fin_q;
		opcode_d   = opcode_q;
		masked_d   = masked_q;
		key_d      = key_q;
		len_d      = len_q;
		idx_d      = idx_q;
		frag_bin_d = frag_bin_q;
		closed_d   = closed_q;

		res_valid       = 1'b0;
		res.data_valid  = 1'b0;
		res.data_byte   = 8'd0;
		res.frame_end   = 1'b0;
		res.event_code  = wsdf_pkg::EV_NONE;
		res.is_closed   = closed_q;

		if (closed_q) begin
			res_valid = 1'b1;
		end else begin
			unique case (phase_q)
				wsdf_pkg::PH_HDR1: begin
					masked_d = b[7];
					if (b[6:0] == wsdf_pkg::LEN_EXT64) begin
						closed_d       = 1'b1;
						phase_d        = wsdf_pkg::PH_HDR0;
						res_valid      = 1'b1;
						res.frame_end  = 1'b1;
						res.event_code = wsdf_pkg::EV_BADLEN;
						res.is_closed  = 1'b1;
					end else if (b[6:0] == wsdf_pkg::LEN_EXT16) begin
						phase_d = wsdf_pkg::PH_EXTHI;
					end else begin
						len_d          = {9'd0, b[6:0]};
						need_after_len = 1'b1;
					end
				end
				wsdf_pkg::PH_EXTHI: begin
					len_d   = {b, 8'd0};
					phase_d = wsdf_pkg::PH_EXTLO;
				end
				wsdf_pkg::PH_EXTLO: begin
					len_d          = {len_q[15:8], b};
					need_after_len = 1'b1;
				end
				wsdf_pkg::PH_MASK: begin
					key_d[{idx_q[1:0], 3'b000} +: 8] = b;
					idx_d = idx_inc;
					if (idx_inc >= 16'd4) begin
						need_hdr_done = 1'b1;
					end
				end
				wsdf_pkg::PH_DATA: begin
					idx_d = idx_inc;
					if (idx_inc >= len_q) begin
						end_frame = 1'b1;
						end_dv    = 1'b1;
						end_db    = masked_q ? (b ^ key_byte) : b;
					end else begin
						res_valid      = 1'b1;
						res.data_valid = 1'b1;
						res.data_byte  = masked_q ? (b ^ key_byte) : b;
					end
				end
				default: begin
					fin_d    = b[7];
					opcode_d = b[3:0];
					phase_d  = wsdf_pkg::PH_HDR1;
				end
			endcase

			if (need_after_len) begin
				if (masked_d) begin
					key_d   = 32'd0;
					idx_d   = 16'd0;
					phase_d = wsdf_pkg::PH_MASK;
				end else begin
					need_hdr_done = 1'b1;
				end
			end

			if (need_hdr_done) begin
				idx_d = 16'd0;
				if (len_d == 16'd0) begin
					end_frame = 1'b1;
				end else begin
					phase_d = wsdf_pkg::PH_DATA;
				end
			end

			if (end_frame) begin
				case (opcode_q)
					wsdf_pkg::OP_CLOSE: begin
						ev       = wsdf_pkg::EV_CLOSE;
						closed_d = 1'b1;
					end
					wsdf_pkg::OP_PING: ev = wsdf_pkg::EV_PING;
					wsdf_pkg::OP_PONG: ev = wsdf_pkg::EV_PONG;
					wsdf_pkg::OP_TEXT: begin
						if (fin_q) begin
							ev = wsdf_pkg::EV_TEXT;
						end else begin
							ev         = wsdf_pkg::EV_FRAGMENT;
							frag_bin_d = 1'b0;
						end
					end
					wsdf_pkg::OP_BINARY: begin
						if (fin_q) begin
							ev = wsdf_pkg::EV_BINARY;
						end else begin
							ev         = wsdf_pkg::EV_FRAGMENT;
							frag_bin_d = 1'b1;
						end
					end
					wsdf_pkg::OP_CONT: begin
						if (!fin_q) begin
							ev = wsdf_pkg::EV_FRAGMENT;
						end else if (frag_bin_q) begin
							ev = wsdf_pkg::EV_BINARY;
						end else begin
							ev = wsdf_pkg::EV_TEXT;
						end
					end
					default: ev = wsdf_pkg::EV_BADOP;
				endcase
				phase_d        = wsdf_pkg::PH_HDR0;
				res_valid      = 1'b1;
				res.data_valid = end_dv;
				res.data_byte  = end_db;
				res.frame_end  = 1'b1;
				res.event_code = ev;
				res.is_closed  = closed_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsdf_pkg::PH_HDR0;
			fin_q      <= 1'b0;
			opcode_q   <= 4'd0;
			masked_q   <= 1'b0;
			key_q      <= 32'd0;
			len_q      <= 16'd0;
			idx_q      <= 16'd0;
			frag_bin_q <= 1'b0;
			closed_q   <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			opcode_q   <= opcode_d;
			masked_q   <= masked_d;
			key_q      <= key_d;
			len_q      <= len_d;
			idx_q      <= idx_d;
			frag_bin_q <= frag_bin_d;
			closed_q   <= closed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.data_byte;
	assign m_axis_tuser  = {out_q.is_closed, out_q.event_code, out_q.data_valid};
	assign m_axis_tlast  = out_q.frame_end;

	// closed state is sticky until reset
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed state left without reset");

	// a completed frame always carries an event, other results never do
	a_end_has_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[4:1] != wsdf_pkg::EV_NONE)))
		else $error("frame end and event code disagree");

	// close and unsupported length results already show the closed flag
	a_close_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[4:1] == wsdf_pkg::EV_CLOSE ||
			m_axis_tuser[4:1] == wsdf_pkg::EV_BADLEN) |-> m_axis_tuser[5])
		else $error("closing event without closed flag");

	// payload bytes only come out of the data phase
	a_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.data_valid |-> phase_q == wsdf_pkg::PH_DATA)
		else $error("payload byte outside data phase");

endmodule
